>>> rtl/jsu_pkg.sv
// shared types, character codes and helper functions for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // utf-8 encoding constants
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] UTF8_MAX1  = 16'h0080;
    localparam logic [15:0] UTF8_MAX2  = 16'h0800;

    // results one input byte can cause
    localparam int MAX_RES = 4;

    // default depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // decoder modes
    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESCAPE = 4'b0010,
        MODE_HEX    = 4'b0100,
        MODE_DONE   = 4'b1000
    } mode_t;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fin;
    } res_t;

    // all results of one input byte, entry 0 goes out first
    typedef struct packed {
        logic [2:0]             cnt;
        res_t [MAX_RES-1:0]     res;
    } bundle_t;

    // hex digit value, zero for anything else
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) v = c[3:0];
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            v = c[3:0] + 4'd9;
        return v;
    endfunction

    // character given by a simple escape
    function automatic logic [7:0] esc_char(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            CH_N:    r = CH_LF;
            CH_R:    r = CH_CR;
            CH_T:    r = CH_TAB;
            default: r = e;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/jsu_front.sv
// front end: escape state machine that turns each input byte into a result bundle
`timescale 1ns / 1ps

module jsu_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 in_end,
    input  logic                 q_full,
    output logic                 in_ready,
    output logic                 push,
    output jsu_pkg::bundle_t     push_bundle
);

    jsu_pkg::mode_t   mode_reg, mode_next;
    logic [1:0]       digits_reg, digits_next;
    logic [15:0]      cp_reg, cp_next;
    logic [7:0]       held_reg [0:2];
    logic             held_we;
    logic             accept;

    jsu_pkg::res_t    res [0:jsu_pkg::MAX_RES-1];
    logic [2:0]       k;
    logic [15:0]      cp_shift;
    logic [7:0]       tail [0:3];
    logic [2:0]       tail_len;
    logic             skip;
    logic             closed;
    logic [7:0]       c;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cp_shift = {cp_reg[11:0], jsu_pkg::hex_val(in_byte)};

    // decode one byte into up to four results
    always_comb
    begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        cp_next     = cp_reg;
        held_we     = 1'b0;
        k           = 3'd0;
        skip        = 1'b0;
        closed      = 1'b0;
        c           = 8'd0;
        for (int i = 0; i < jsu_pkg::MAX_RES; i++)
        begin
            res[i] = '0;
        end
        for (int j = 0; j < 3; j++)
        begin
            tail[j] = (2'(j) < digits_reg) ? held_reg[j[1:0]] : in_byte;
        end
        tail[3]  = in_byte;
        tail_len = {1'b0, digits_reg} + 3'd1;

        case (mode_reg)
            jsu_pkg::MODE_DONE:
            begin
                if (in_end) mode_next = jsu_pkg::MODE_NORMAL;
            end
            jsu_pkg::MODE_NORMAL:
            begin
                if (in_byte == jsu_pkg::CH_QUOTE)
                begin
                    res[0]    = '{data: 8'd0, has: 1'b0, fin: 1'b1};
                    k         = 3'd1;
                    mode_next = in_end ? jsu_pkg::MODE_NORMAL : jsu_pkg::MODE_DONE;
                end
                else if (in_byte == jsu_pkg::CH_BSLASH && !in_end)
                begin
                    mode_next = jsu_pkg::MODE_ESCAPE;
                end
                else
                begin
                    res[0] = '{data: in_byte, has: 1'b1, fin: 1'b0};
                    k      = 3'd1;
                end
            end
            jsu_pkg::MODE_ESCAPE:
            begin
                mode_next = jsu_pkg::MODE_NORMAL;
                if (in_byte == jsu_pkg::CH_U && !in_end)
                begin
                    mode_next   = jsu_pkg::MODE_HEX;
                    digits_next = 2'd0;
                    cp_next     = 16'd0;
                end
                else
                begin
                    res[0] = '{data: jsu_pkg::esc_char(in_byte), has: 1'b1, fin: 1'b0};
                    k      = 3'd1;
                end
            end
            jsu_pkg::MODE_HEX:
            begin
                cp_next = cp_shift;
                if (digits_reg == 2'd3)
                begin
                    // fourth digit: encode the code point as utf-8
                    mode_next   = jsu_pkg::MODE_NORMAL;
                    digits_next = 2'd0;
                    if (cp_shift < jsu_pkg::UTF8_MAX1)
                    begin
                        res[0] = '{data: cp_shift[7:0], has: 1'b1, fin: 1'b0};
                        k      = 3'd1;
                    end
                    else if (cp_shift < jsu_pkg::UTF8_MAX2)
                    begin
                        res[0] = '{data: jsu_pkg::UTF8_LEAD2 | {3'd0, cp_shift[10:6]},
                                   has: 1'b1, fin: 1'b0};
                        res[1] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp_shift[5:0]},
                                   has: 1'b1, fin: 1'b0};
                        k      = 3'd2;
                    end
                    else
                    begin
                        res[0] = '{data: jsu_pkg::UTF8_LEAD3 | {4'd0, cp_shift[15:12]},
                                   has: 1'b1, fin: 1'b0};
                        res[1] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp_shift[11:6]},
                                   has: 1'b1, fin: 1'b0};
                        res[2] = '{data: jsu_pkg::UTF8_CONT | {2'd0, cp_shift[5:0]},
                                   has: 1'b1, fin: 1'b0};
                        k      = 3'd3;
                    end
                end
                else if (!in_end)
                begin
                    held_we     = 1'b1;
                    digits_next = digits_reg + 2'd1;
                end
                else
                begin
                    // short escape at payload end: emit 'u' and decode the tail as text
                    mode_next   = jsu_pkg::MODE_NORMAL;
                    digits_next = 2'd0;
                    res[0]      = '{data: jsu_pkg::CH_U, has: 1'b1, fin: 1'b0};
                    k           = 3'd1;
                    for (int j = 0; j < 3; j++)
                    begin
                        if (skip)
                        begin
                            skip = 1'b0;
                        end
                        else if (3'(j) < tail_len && !closed)
                        begin
                            c = tail[j[1:0]];
                            if (c == jsu_pkg::CH_QUOTE)
                            begin
                                res[k[1:0]] = '{data: 8'd0, has: 1'b0, fin: 1'b1};
                                k           = k + 3'd1;
                                closed      = 1'b1;
                            end
                            else if (c == jsu_pkg::CH_BSLASH && 3'(j + 1) < tail_len)
                            begin
                                res[k[1:0]] = '{data: jsu_pkg::esc_char(tail[2'(j + 1)]),
                                                has: 1'b1, fin: 1'b0};
                                k           = k + 3'd1;
                                skip        = 1'b1;
                            end
                            else
                            begin
                                res[k[1:0]] = '{data: c, has: 1'b1, fin: 1'b0};
                                k           = k + 3'd1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                mode_next = jsu_pkg::MODE_NORMAL;
            end
        endcase

        // payload end closes the string on the final result
        if (k != 3'd0 && in_end)
        begin
            res[2'(k - 3'd1)].fin = 1'b1;
        end
    end

    // pack the bundle for the queue
    always_comb
    begin
        push_bundle.cnt = k;
        for (int i = 0; i < jsu_pkg::MAX_RES; i++)
        begin
            push_bundle.res[i] = res[i];
        end
    end

    assign push = accept && (k != 3'd0);

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= jsu_pkg::MODE_NORMAL;
            digits_reg <= 2'd0;
            cp_reg     <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            cp_reg     <= cp_next;
        end
    end

    // raw digit bytes of an open unicode escape
    always_ff @(posedge clk)
    begin
        if (accept && held_we)
        begin
            held_reg[digits_reg] <= in_byte;
        end
    end

    // digits are only held while a unicode escape is open
    assert property (@(posedge clk) disable iff (!rst_n)
        (digits_reg != 2'd0) |-> (mode_reg == jsu_pkg::MODE_HEX))
        else $error("hex digit count set outside hex mode");

    // bytes after a closing quote give no results
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == jsu_pkg::MODE_DONE) |-> !push)
        else $error("result produced in done mode");

    // a payload end always leaves the decoder in normal mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_end) |=> (mode_reg == jsu_pkg::MODE_NORMAL))
        else $error("decoder not back in normal mode after payload end");

    // never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

endmodule

>>> rtl/jsu_queue.sv
// small queue of result bundles between front and back
`timescale 1ns / 1ps

module jsu_queue
#(
    parameter int DEPTH = jsu_pkg::FIFO_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jsu_pkg::bundle_t     push_data,
    input  logic                 pop,
    output jsu_pkg::bundle_t     pop_data,
    output logic                 full,
    output logic                 not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::bundle_t mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> rtl/jsu_back.sv
// back end: sends the results of each bundle one transaction at a time
`timescale 1ns / 1ps

module jsu_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  jsu_pkg::bundle_t     q_data,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    jsu_pkg::bundle_t cur_reg;
    logic             busy_reg;
    logic [1:0]       idx_reg;
    jsu_pkg::res_t    beat;
    logic             is_last;
    logic             beat_done;
    logic             load;

    assign beat      = cur_reg.res[idx_reg];
    assign is_last   = ({1'b0, idx_reg} == (cur_reg.cnt - 3'd1));
    assign beat_done = busy_reg && m_tready && is_last;
    assign load      = q_valid && (!busy_reg || beat_done);
    assign q_pop     = load;

    // output fields
    assign m_tvalid = busy_reg;
    assign m_tdata  = beat.data;
    assign m_tuser  = {beat.fin, beat.has};
    assign m_tlast  = is_last;

    // current bundle and position in it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (beat_done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && m_tready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

>>> rtl/json_string_unescape_utf8_core.sv
// Top level of the json string unescaper with utf-8 output.
// Results pass through the bundle queue and the back end's bundle register before output.
// Throughput: one byte in per cycle while the queue has room; one result out per ready cycle.
// An input byte gives zero to four results; the output side, one result a cycle, sets the rate.
// Reset (rst_n low, asynchronous) empties the queue and returns the decoder to normal mode;
// the held hex digit bytes are not cleared.
`timescale 1ns / 1ps

module json_string_unescape_utf8_core
#(
    parameter int FIFO_DEPTH = jsu_pkg::FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // payload_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] has_byte, [1] string_end
    output logic        m_tlast    // last
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_not_empty;
    jsu_pkg::bundle_t push_bundle;
    jsu_pkg::bundle_t pop_bundle;

    // decoder front end
    jsu_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .in_end      (s_tlast),
        .q_full      (q_full),
        .in_ready    (s_tready),
        .push        (push),
        .push_bundle (push_bundle)
    );

    // bundle queue
    jsu_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_bundle),
        .pop       (pop),
        .pop_data  (pop_bundle),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    // result serializer
    jsu_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_data   (pop_bundle),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> bench/tb_json_string_unescape_utf8_core.sv
// self-checking testbench for the json string unescaper: directed and random payloads
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_core;

    // one decoded result as seen on the master side
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fin;
        logic       lst;
    } decoded_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // decoder model state
    jsu_pkg::mode_t dec_mode  = jsu_pkg::MODE_NORMAL;
    logic [1:0]     digit_cnt = 2'd0;
    logic [15:0]    cp_acc    = 16'h0000;
    logic [7:0]     digit_buf [3];

    decoded_t    step_res [$];
    decoded_t    expected_q [$];
    logic [7:0]  payload_q [$];

    bit          no_idle       = 1'b0;
    int          err_count     = 0;
    int          bytes_sent    = 0;
    int          payloads_sent = 0;
    int          results_seen  = 0;
    int          utf8_len_hits [1:3] = '{0, 0, 0};

    json_string_unescape_utf8_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always #2 clk = ~clk;

    // receiver backpressure
    always @(negedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 18);
    end

    // hard stop
    initial
    begin
        #400_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------

    // value of a hex digit, zero for anything else
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]})      d = c - 8'h30;   // 0-9
        else if (c inside {[8'h61:8'h66]}) d = c - 8'h57;   // a-f
        else if (c inside {[8'h41:8'h46]}) d = c - 8'h37;   // A-F
        return d[3:0];
    endfunction

    // byte given by a one-character escape
    function automatic logic [7:0] unescaped(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == jsu_pkg::CH_N)      r = jsu_pkg::CH_LF;
        else if (c == jsu_pkg::CH_R) r = jsu_pkg::CH_CR;
        else if (c == jsu_pkg::CH_T) r = jsu_pkg::CH_TAB;
        return r;
    endfunction

    function automatic void add_result(input logic [7:0] b, input logic has, input logic fin);
        decoded_t r;
        r.data = has ? b : 8'h00;
        r.has  = has;
        r.fin  = fin;
        r.lst  = 1'b0;
        step_res.push_back(r);
    endfunction

    // code point to 1, 2 or 3 utf-8 bytes
    function automatic void emit_utf8(input logic [15:0] cp);
        if (cp < jsu_pkg::UTF8_MAX1)
        begin
            add_result(cp[7:0], 1'b1, 1'b0);
            utf8_len_hits[1]++;
        end
        else if (cp < jsu_pkg::UTF8_MAX2)
        begin
            add_result({3'b110, cp[10:6]}, 1'b1, 1'b0);
            add_result({2'b10, cp[5:0]}, 1'b1, 1'b0);
            utf8_len_hits[2]++;
        end
        else
        begin
            add_result({4'b1110, cp[15:12]}, 1'b1, 1'b0);
            add_result({2'b10, cp[11:6]}, 1'b1, 1'b0);
            add_result({2'b10, cp[5:0]}, 1'b1, 1'b0);
            utf8_len_hits[3]++;
        end
    endfunction

    // truncated \u at payload end: 'u' then the held bytes replayed as plain text
    function automatic void replay_short_escape(input int n, input logic [7:0] b);
        logic [7:0] tail [4];
        int         len;
        int         i;
        bit         closed;
        for (i = 0; i < n; i++)
            tail[i] = digit_buf[i];
        tail[n] = b;
        len     = n + 1;
        i       = 0;
        closed  = 1'b0;
        add_result(jsu_pkg::CH_U, 1'b1, 1'b0);
        while (i < len && !closed)
        begin
            if (tail[i] == jsu_pkg::CH_QUOTE)
            begin
                add_result(8'h00, 1'b0, 1'b1);
                closed = 1'b1;
            end
            else if (tail[i] == jsu_pkg::CH_BSLASH && i + 1 < len)
            begin
                add_result(unescaped(tail[i + 1]), 1'b1, 1'b0);
                i += 2;
            end
            else
            begin
                add_result(tail[i], 1'b1, 1'b0);
                i++;
            end
        end
    endfunction

    // expected results of one accepted input byte
    function automatic void predict_byte(input logic [7:0] b, input logic e);
        logic [15:0] cp;
        decoded_t    final_res;
        step_res.delete();
        case (dec_mode)
            jsu_pkg::MODE_DONE:
            begin
                if (e)
                    dec_mode = jsu_pkg::MODE_NORMAL;
            end
            jsu_pkg::MODE_NORMAL:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                begin
                    add_result(8'h00, 1'b0, 1'b1);
                    if (!e)
                        dec_mode = jsu_pkg::MODE_DONE;
                end
                else if (b == jsu_pkg::CH_BSLASH && !e)
                    dec_mode = jsu_pkg::MODE_ESCAPE;
                else
                    add_result(b, 1'b1, 1'b0);
            end
            jsu_pkg::MODE_ESCAPE:
            begin
                if (b == jsu_pkg::CH_U && !e)
                begin
                    dec_mode  = jsu_pkg::MODE_HEX;
                    digit_cnt = 2'd0;
                    cp_acc    = 16'h0000;
                end
                else
                begin
                    dec_mode = jsu_pkg::MODE_NORMAL;
                    add_result(unescaped(b), 1'b1, 1'b0);
                end
            end
            default:
            begin
                cp     = {cp_acc[11:0], digit_value(b)};
                cp_acc = cp;
                if (digit_cnt == 2'd3)
                begin
                    dec_mode  = jsu_pkg::MODE_NORMAL;
                    digit_cnt = 2'd0;
                    emit_utf8(cp);
                end
                else if (!e)
                begin
                    digit_buf[digit_cnt] = b;
                    digit_cnt = digit_cnt + 2'd1;
                end
                else
                begin
                    dec_mode = jsu_pkg::MODE_NORMAL;
                    replay_short_escape(digit_cnt, b);
                    digit_cnt = 2'd0;
                end
            end
        endcase
        // mark the last result of this byte, and the string end at payload end
        if (step_res.size() > 0)
        begin
            final_res     = step_res.pop_back();
            final_res.lst = 1'b1;
            if (e)
                final_res.fin = 1'b1;
            step_res.push_back(final_res);
        end
        foreach (step_res[k])
            expected_q.push_back(step_res[k]);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_result();
        decoded_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result data=%02h user=%b last=%b",
                                      m_tdata, m_tuser, m_tlast));
        end
        else
        begin
            want = expected_q.pop_front();
            results_seen++;
            if (m_tdata !== want.data)
                report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
            if (m_tuser[0] !== want.has)
                report_mismatch($sformatf("has_byte %b, want %b", m_tuser[0], want.has));
            if (m_tuser[1] !== want.fin)
                report_mismatch($sformatf("string_end %b, want %b", m_tuser[1], want.fin));
            if (m_tlast !== want.lst)
                report_mismatch($sformatf("last %b, want %b", m_tlast, want.lst));
        end
    endtask

    // every master-side transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one slave-side transaction; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic e);
        while (!no_idle && $urandom_range(0, 99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= e;
        do
            @(posedge clk);
        while (!s_tready);
        predict_byte(b, e);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_payload();
        int i;
        for (i = 0; i < payload_q.size(); i++)
            send_byte(payload_q[i], i == payload_q.size() - 1);
        payloads_sent++;
        payload_q.delete();
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            payload_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] base;
        if (nib < 4'd10)
            base = 8'h30;
        else
            base = ($urandom_range(0, 1) == 0) ? 8'h57 : 8'h37;
        return base + {4'h0, nib};
    endfunction

    // byte that follows a backslash
    function automatic logic [7:0] escape_pick();
        logic [7:0] r;
        case ($urandom_range(0, 6))
            0:       r = jsu_pkg::CH_N;
            1:       r = jsu_pkg::CH_R;
            2:       r = jsu_pkg::CH_T;
            3:       r = jsu_pkg::CH_QUOTE;
            4:       r = jsu_pkg::CH_BSLASH;
            5:       r = 8'h2F;
            default: r = 8'($urandom);
        endcase
        return r;
    endfunction

    // byte inside a truncated \u escape
    function automatic logic [7:0] tail_pick();
        logic [7:0] r;
        case ($urandom_range(0, 5))
            0:       r = hex_char(4'($urandom));
            1:       r = jsu_pkg::CH_QUOTE;
            2:       r = jsu_pkg::CH_BSLASH;
            3:       r = jsu_pkg::CH_U;
            4:       r = jsu_pkg::CH_N;
            default: r = 8'($urandom);
        endcase
        return r;
    endfunction

    // plain byte, simple escape, \uXXXX or noise
    task automatic push_token();
        int          pick;
        int          k;
        logic [15:0] cp;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            b = 8'($urandom);
            if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH)
                b = jsu_pkg::CH_T;
            payload_q.push_back(b);
        end
        else if (pick < 55)
        begin
            payload_q.push_back(jsu_pkg::CH_BSLASH);
            payload_q.push_back(escape_pick());
        end
        else if (pick < 88)
        begin
            case ($urandom_range(0, 2))
                0:       cp = 16'($urandom_range(0, 16'h007F));
                1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            payload_q.push_back(jsu_pkg::CH_BSLASH);
            payload_q.push_back(jsu_pkg::CH_U);
            for (k = 3; k >= 0; k--)
                payload_q.push_back(hex_char(cp[4 * k +: 4]));
            // now and then a bad digit, a quote among them
            if ($urandom_range(0, 9) == 0)
                payload_q[payload_q.size() - 1 - $urandom_range(0, 3)] =
                    ($urandom_range(0, 1) == 0) ? jsu_pkg::CH_QUOTE : 8'($urandom);
        end
        else
            payload_q.push_back(8'($urandom));
    endtask

    task automatic build_random_payload();
        repeat ($urandom_range(1, 6))
            push_token();
        case ($urandom_range(0, 9))
            0, 1: payload_q.push_back(jsu_pkg::CH_QUOTE);
            2, 3:
            begin
                payload_q.push_back(jsu_pkg::CH_QUOTE);
                repeat ($urandom_range(1, 3))
                    payload_q.push_back(8'($urandom));
            end
            4, 5:
            begin
                payload_q.push_back(jsu_pkg::CH_BSLASH);
                payload_q.push_back(jsu_pkg::CH_U);
                repeat ($urandom_range(1, 3))
                    payload_q.push_back(tail_pick());
            end
            6: payload_q.push_back(jsu_pkg::CH_BSLASH);
            7:
            begin
                payload_q.push_back(jsu_pkg::CH_BSLASH);
                payload_q.push_back(escape_pick());
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero and all-ones bytes, closing quote, ignored bytes in done mode, lone quote at end
    task automatic test_plain_and_close();
        payload_q.push_back(8'h00);
        payload_q.push_back(8'hFF);
        payload_q.push_back(jsu_pkg::CH_QUOTE);
        push_text("x");
        payload_q.push_back(8'h80);
        send_payload();
        payload_q.push_back(jsu_pkg::CH_QUOTE);
        send_payload();
    endtask

    // the n, r and t escapes, escaped quote and backslash, an unknown escape at payload end, backslash at payload end
    task automatic test_simple_escapes();
        push_text("\\n\\r\\t\\\"\\\\\\q");
        send_payload();
        payload_q.push_back(jsu_pkg::CH_BSLASH);
        send_payload();
    endtask

    // 3-byte code point with a quote and a bad digit inside, then a truncated \u
    task automatic test_unicode_escapes();
        push_text("\\uF\"g9");
        send_payload();
        push_text("\\u\"");
        send_payload();
    endtask

    task automatic test_random_payloads(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            build_random_payload();
            send_payload();
        end
    endtask

    // sender holds off until the output side has drained
    task automatic test_drain_pause();
        repeat (3)
        begin
            build_random_payload();
            send_payload();
        end
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // both sides at full rate
    task automatic test_full_rate_burst();
        no_idle = 1'b1;
        test_random_payloads(80);
        no_idle = 1'b0;
    endtask

    // drain with a bound, then a few quiet cycles for stray results
    task automatic drain_and_summarize();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));
        $display("run: %0d bytes in %0d payloads, %0d results checked",
                 bytes_sent, payloads_sent, results_seen);
        $display("run: utf-8 code points of 1/2/3 bytes: %0d/%0d/%0d",
                 utf8_len_hits[1], utf8_len_hits[2], utf8_len_hits[3]);
    endtask

    // main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_plain_and_close();
        test_simple_escapes();
        test_unicode_escapes();
        test_random_payloads(140);
        test_drain_pause();
        test_full_rate_burst();
        test_random_payloads(120);
        drain_and_summarize();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
